[rtl/double_array_trie_engine_defines.svh]
// ---------------------------------------------------------------------------
// double_array_trie_engine_defines
// Assertion macros for the double-array trie engine.
// Each macro is empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef DOUBLE_ARRAY_TRIE_ENGINE_DEFINES_SVH
`define DOUBLE_ARRAY_TRIE_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
`define DAT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DAT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define DAT_ASSERT(lbl, clk, rst_n, prop, msg)
`define DAT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

[rtl/dat_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dat_pkg
// Shared types and constants of the double-array trie engine.
// ---------------------------------------------------------------------------
package dat_pkg;

  localparam int ADDR_W = 13;
  localparam int CELL_W = 14;

  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic signed [CELL_W-1:0] cell_t;
  typedef logic signed [15:0]       pos_t;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_SYMBOL = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam pos_t NIL_CELL   = 16'sd0;
  localparam pos_t HEAD_CELL  = 16'sd1;
  localparam pos_t ROOT_NODE  = 16'sd2;
  localparam pos_t FIRST_CELL = 16'sd3;

  typedef struct packed {
    logic  re;
    addr_t raddr;
    logic  wbe;
    logic  wce;
    addr_t waddr;
    cell_t wbase;
    cell_t wcheck;
  } mem_req_t;

  typedef struct packed {
    cell_t base;
    cell_t check;
  } cell_rd_t;

  typedef struct packed {
    logic [11:0] node;
    logic [7:0]  symbol;
    logic [1:0]  status;
  } res_t;

endpackage

[rtl/dat_mem.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dat_mem
// Base and check arrays: one read address, registered read data, one write
// address with separate enables for the two fields.
// ---------------------------------------------------------------------------
module dat_mem #(
  parameter int CELLS = 4096
) (
  input  logic              clk_i,
  input  dat_pkg::mem_req_t req_i,
  output dat_pkg::cell_rd_t rd_o
);

  localparam int AW = $clog2(CELLS);

  dat_pkg::cell_t base_mem [CELLS];
  dat_pkg::cell_t check_mem[CELLS];
  dat_pkg::cell_rd_t rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wbe) begin
      base_mem[req_i.waddr[AW-1:0]] <= req_i.wbase;
    end
    if (req_i.wce) begin
      check_mem[req_i.waddr[AW-1:0]] <= req_i.wcheck;
    end
    if (req_i.re) begin
      rd_q.base  <= base_mem[req_i.raddr[AW-1:0]];
      rd_q.check <= check_mem[req_i.raddr[AW-1:0]];
    end
  end

  assign rd_o = rd_q;

endmodule

[rtl/dat_seq.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dat_seq
// Sequencer: init sweep, lookup, parent-symbol read, free-list base search, sibling relocation
// and free-list maintenance, at most one memory access per cycle.
// ---------------------------------------------------------------------------
`include "double_array_trie_engine_defines.svh"

module dat_seq #(
  parameter int CELLS   = 4096,
  parameter int SYMBOLS = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        kind_i,
  input  logic [11:0]       node_i,
  input  logic [7:0]        symbol_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output dat_pkg::res_t     res_o,
  output dat_pkg::mem_req_t mem_req_o,
  input  dat_pkg::cell_rd_t mem_rd_i
);

  localparam int AW = $clog2(CELLS);
  localparam int IW = $clog2(SYMBOLS);
  localparam dat_pkg::pos_t CELLS_P = dat_pkg::pos_t'(CELLS);
  localparam dat_pkg::pos_t SYMS_P  = dat_pkg::pos_t'(SYMBOLS);

  typedef enum logic [26:0] {
    S_INIT    = 27'd1 << 0,
    S_IDLE    = 27'd1 << 1,
    S_NODE    = 27'd1 << 2,
    S_PAR     = 27'd1 << 3,
    S_SLOT    = 27'd1 << 4,
    S_COL     = 27'd1 << 5,
    S_COL_CHK = 27'd1 << 6,
    S_FHEAD   = 27'd1 << 7,
    S_FLOOP   = 27'd1 << 8,
    S_FIT     = 27'd1 << 9,
    S_FIT_CHK = 27'd1 << 10,
    S_FNEXT   = 27'd1 << 11,
    S_PL_RD   = 27'd1 << 12,
    S_MV      = 27'd1 << 13,
    S_MV_CHK  = 27'd1 << 14,
    S_UL      = 27'd1 << 15,
    S_ULP     = 27'd1 << 16,
    S_ULN     = 27'd1 << 17,
    S_PL_W    = 27'd1 << 18,
    S_MV_WN   = 27'd1 << 19,
    S_GC      = 27'd1 << 20,
    S_GC_CHK  = 27'd1 << 21,
    S_LK_RD   = 27'd1 << 22,
    S_LK      = 27'd1 << 23,
    S_LKT     = 27'd1 << 24,
    S_LKH     = 27'd1 << 25,
    S_DONE    = 27'd1 << 26
  } state_e;

  state_e state_q, state_d;
  logic [AW-1:0] init_q, init_d;
  logic [1:0]    kind_q, kind_d;
  logic [11:0]   node_q, node_d;
  logic [7:0]    sym_q, sym_d;
  dat_pkg::cell_t nb_q, nb_d;
  dat_pkg::cell_t mvb_q, mvb_d;
  dat_pkg::pos_t b_q, b_d;
  dat_pkg::pos_t s_q, s_d;
  dat_pkg::pos_t p_q, p_d;
  dat_pkg::pos_t nx_q, nx_d;
  dat_pkg::pos_t tail_q, tail_d;
  logic [AW:0]   guard_q, guard_d;
  logic [IW:0]   i_q, i_d;
  logic [IW:0]   j_q, j_d;
  logic [7:0]    lo_q, lo_d;
  logic [7:0]    hi_q, hi_d;
  logic [SYMBOLS-1:0] kids_q, kids_d;
  logic          newbase_q, newbase_d;
  logic          ulmv_q, ulmv_d;
  dat_pkg::addr_t o_q, o_d;
  dat_pkg::addr_t n_q, n_d;
  dat_pkg::addr_t g_q, g_d;
  dat_pkg::addr_t slot_q, slot_d;
  logic [11:0]   rnode_q, rnode_d;
  logic [7:0]    rsym_q, rsym_d;
  logic [1:0]    st_q, st_d;
  dat_pkg::mem_req_t req;

  function automatic logic in_rng(input dat_pkg::pos_t x);
    return (x >= 16'sd0) && (x < CELLS_P);
  endfunction

  function automatic dat_pkg::addr_t ad(input dat_pkg::pos_t x);
    return x[dat_pkg::ADDR_W-1:0];
  endfunction

  always_comb begin
    dat_pkg::pos_t np, sp, ip, jp, rb, rc, o, n, g, b, slot_n, ipos;
    logic live;
    np     = dat_pkg::pos_t'(node_q);
    sp     = dat_pkg::pos_t'(sym_q);
    ip     = dat_pkg::pos_t'(i_q);
    jp     = dat_pkg::pos_t'(j_q);
    rb     = dat_pkg::pos_t'(mem_rd_i.base);
    rc     = dat_pkg::pos_t'(mem_rd_i.check);
    o      = dat_pkg::pos_t'(nb_q) + ip;
    n      = b_q + ip;
    g      = dat_pkg::pos_t'(mvb_q) + jp;
    b      = s_q - dat_pkg::pos_t'(lo_q);
    slot_n = rb + sp;
    ipos   = dat_pkg::pos_t'(init_q);
    live   = (np != dat_pkg::NIL_CELL) && (np != dat_pkg::HEAD_CELL) && (rc >= 16'sd0);

    state_d = state_q;   init_d = init_q;   kind_d = kind_q;   node_d = node_q;
    sym_d = sym_q;       nb_d = nb_q;       mvb_d = mvb_q;     b_d = b_q;
    s_d = s_q;           p_d = p_q;         nx_d = nx_q;       tail_d = tail_q;
    guard_d = guard_q;   i_d = i_q;         j_d = j_q;         lo_d = lo_q;
    hi_d = hi_q;         kids_d = kids_q;   newbase_d = newbase_q;
    ulmv_d = ulmv_q;     o_d = o_q;         n_d = n_q;         g_d = g_q;
    slot_d = slot_q;     rnode_d = rnode_q; rsym_d = rsym_q;   st_d = st_q;
    req = '0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      S_INIT: begin
        req.wbe   = 1'b1;
        req.wce   = 1'b1;
        req.waddr = dat_pkg::addr_t'(init_q);
        if (ipos == 16'sd0) begin
          req.wbase  = '0;
          req.wcheck = '0;
        end else if (ipos == dat_pkg::HEAD_CELL) begin
          req.wbase  = dat_pkg::cell_t'(-(CELLS_P - 16'sd1));
          req.wcheck = dat_pkg::cell_t'(-dat_pkg::FIRST_CELL);
        end else if (ipos == dat_pkg::ROOT_NODE) begin
          req.wbase  = dat_pkg::cell_t'(dat_pkg::FIRST_CELL);
          req.wcheck = dat_pkg::cell_t'(dat_pkg::ROOT_NODE);
        end else begin
          req.wcheck = (ipos == CELLS_P - 16'sd1) ? dat_pkg::cell_t'(-dat_pkg::HEAD_CELL)
                                                  : dat_pkg::cell_t'(-(ipos + 16'sd1));
          req.wbase  = (ipos == dat_pkg::FIRST_CELL) ? dat_pkg::cell_t'(-dat_pkg::HEAD_CELL)
                                                     : dat_pkg::cell_t'(-(ipos - 16'sd1));
        end
        if (init_q == AW'(CELLS - 1)) begin
          state_d = S_IDLE;
        end else begin
          init_d = init_q + 1'b1;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          kind_d  = kind_i;
          node_d  = node_i;
          sym_d   = symbol_i;
          rnode_d = '0;
          rsym_d  = '0;
          st_d    = dat_pkg::ST_MISS;
          if (dat_pkg::pos_t'(node_i) >= CELLS_P) begin
            state_d = S_DONE;
          end else begin
            req.re    = 1'b1;
            req.raddr = ad(dat_pkg::pos_t'(node_i));
            state_d   = S_NODE;
          end
        end
      end
      S_NODE: begin
        state_d = S_DONE;
        nb_d    = mem_rd_i.base;
        if (live) begin
          case (kind_q)
            dat_pkg::KIND_SYMBOL: begin
              if (np == dat_pkg::ROOT_NODE || rc >= CELLS_P) begin
                st_d = dat_pkg::ST_OK;
              end else begin
                req.re    = 1'b1;
                req.raddr = ad(rc);
                state_d   = S_PAR;
              end
            end
            dat_pkg::KIND_LOOKUP: begin
              if (sp < SYMS_P && rb >= 16'sd0 && slot_n < CELLS_P) begin
                req.re    = 1'b1;
                req.raddr = ad(slot_n);
                slot_d    = ad(slot_n);
                state_d   = S_SLOT;
              end
            end
            dat_pkg::KIND_INSERT: begin
              if (sp < SYMS_P) begin
                lo_d = sym_q;
                hi_d = sym_q;
                kids_d = '0;
                if (rb < 16'sd0) begin
                  kids_d[sym_q[IW-1:0]] = 1'b1;
                  newbase_d = 1'b1;
                  req.re    = 1'b1;
                  req.raddr = ad(dat_pkg::HEAD_CELL);
                  state_d   = S_FHEAD;
                end else if (slot_n < CELLS_P) begin
                  req.re    = 1'b1;
                  req.raddr = ad(slot_n);
                  slot_d    = ad(slot_n);
                  state_d   = S_SLOT;
                end else begin
                  i_d     = '0;
                  state_d = S_COL;
                end
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_PAR: begin
        rsym_d  = 8'(np - rb);
        st_d    = dat_pkg::ST_OK;
        state_d = S_DONE;
      end
      S_SLOT: begin
        if (rc == np) begin
          rnode_d = 12'(slot_q);
          st_d    = dat_pkg::ST_OK;
          state_d = S_DONE;
        end else if (kind_q == dat_pkg::KIND_LOOKUP) begin
          state_d = S_DONE;
        end else if (rc >= 16'sd0) begin
          kids_d  = '0;
          i_d     = '0;
          state_d = S_COL;
        end else begin
          req.re    = 1'b1;
          req.raddr = slot_q;
          ulmv_d    = 1'b0;
          state_d   = S_UL;
        end
      end
      S_COL: begin
        if (ip == SYMS_P || o >= CELLS_P) begin
          kids_d[sym_q[IW-1:0]] = 1'b1;
          newbase_d = 1'b0;
          req.re    = 1'b1;
          req.raddr = ad(dat_pkg::HEAD_CELL);
          state_d   = S_FHEAD;
        end else begin
          req.re    = 1'b1;
          req.raddr = ad(o);
          state_d   = S_COL_CHK;
        end
      end
      S_COL_CHK: begin
        if (rc == np) begin
          kids_d[i_q[IW-1:0]] = 1'b1;
          if (8'(i_q) < lo_q) lo_d = 8'(i_q);
          if (8'(i_q) > hi_q) hi_d = 8'(i_q);
        end
        i_d     = i_q + 1'b1;
        state_d = S_COL;
      end
      S_FHEAD: begin
        s_d     = -rc;
        guard_d = '0;
        state_d = S_FLOOP;
      end
      S_FLOOP: begin
        if (guard_q == (AW+1)'(CELLS) || s_q == dat_pkg::HEAD_CELL ||
            s_q <= 16'sd0 || s_q >= CELLS_P) begin
          st_d    = dat_pkg::ST_FULL;
          state_d = S_DONE;
        end else if (b < dat_pkg::FIRST_CELL || b + dat_pkg::pos_t'(hi_q) >= CELLS_P) begin
          req.re    = 1'b1;
          req.raddr = ad(s_q);
          state_d   = S_FNEXT;
        end else begin
          b_d     = b;
          i_d     = '0;
          state_d = S_FIT;
        end
      end
      S_FIT: begin
        if (ip == SYMS_P) begin
          if (newbase_q) begin
            req.wbe   = 1'b1;
            req.waddr = ad(np);
            req.wbase = dat_pkg::cell_t'(b_q);
            slot_d    = ad(b_q + sp);
            state_d   = S_PL_RD;
          end else begin
            i_d     = '0;
            state_d = S_MV;
          end
        end else if (kids_q[i_q[IW-1:0]]) begin
          req.re    = 1'b1;
          req.raddr = ad(n);
          state_d   = S_FIT_CHK;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      S_FIT_CHK: begin
        if (rc >= 16'sd0) begin
          req.re    = 1'b1;
          req.raddr = ad(s_q);
          state_d   = S_FNEXT;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_FIT;
        end
      end
      S_FNEXT: begin
        s_d     = -rc;
        guard_d = guard_q + 1'b1;
        state_d = S_FLOOP;
      end
      S_PL_RD: begin
        req.re    = 1'b1;
        req.raddr = slot_q;
        ulmv_d    = 1'b0;
        state_d   = S_UL;
      end
      S_MV: begin
        if (ip == SYMS_P || o >= CELLS_P) begin
          req.wbe   = 1'b1;
          req.waddr = ad(np);
          req.wbase = dat_pkg::cell_t'(b_q);
          slot_d    = ad(b_q + sp);
          state_d   = S_PL_RD;
        end else begin
          req.re    = 1'b1;
          req.raddr = ad(o);
          o_d       = ad(o);
          state_d   = S_MV_CHK;
        end
      end
      S_MV_CHK: begin
        if (rc != np || n >= CELLS_P) begin
          i_d     = i_q + 1'b1;
          state_d = S_MV;
        end else begin
          mvb_d     = mem_rd_i.base;
          n_d       = ad(n);
          ulmv_d    = 1'b1;
          req.re    = 1'b1;
          req.raddr = ad(n);
          state_d   = S_UL;
        end
      end
      S_UL: begin
        p_d     = -rb;
        nx_d    = -rc;
        state_d = S_ULP;
      end
      S_ULP: begin
        if (in_rng(p_q)) begin
          req.wce    = 1'b1;
          req.waddr  = ad(p_q);
          req.wcheck = dat_pkg::cell_t'(-nx_q);
        end
        state_d = S_ULN;
      end
      S_ULN: begin
        if (in_rng(nx_q)) begin
          req.wbe   = 1'b1;
          req.waddr = ad(nx_q);
          req.wbase = dat_pkg::cell_t'(-p_q);
        end
        state_d = ulmv_q ? S_MV_WN : S_PL_W;
      end
      S_PL_W: begin
        req.wbe    = 1'b1;
        req.wce    = 1'b1;
        req.waddr  = slot_q;
        req.wbase  = dat_pkg::cell_t'(-dat_pkg::HEAD_CELL);
        req.wcheck = dat_pkg::cell_t'(np);
        rnode_d    = 12'(slot_q);
        st_d       = dat_pkg::ST_OK;
        state_d    = S_DONE;
      end
      S_MV_WN: begin
        req.wbe    = 1'b1;
        req.wce    = 1'b1;
        req.waddr  = n_q;
        req.wbase  = mvb_q;
        req.wcheck = dat_pkg::cell_t'(np);
        j_d        = '0;
        state_d    = (mvb_q >= 14'sd0) ? S_GC : S_LK_RD;
      end
      S_GC: begin
        if (jp == SYMS_P || g >= CELLS_P) begin
          state_d = S_LK_RD;
        end else begin
          req.re    = 1'b1;
          req.raddr = ad(g);
          g_d       = ad(g);
          state_d   = S_GC_CHK;
        end
      end
      S_GC_CHK: begin
        // grandchild still points at the old cell
        if (rc == dat_pkg::pos_t'(o_q)) begin
          req.wce    = 1'b1;
          req.waddr  = g_q;
          req.wcheck = dat_pkg::cell_t'(n_q);
        end
        j_d     = j_q + 1'b1;
        state_d = S_GC;
      end
      S_LK_RD: begin
        req.re    = 1'b1;
        req.raddr = ad(dat_pkg::HEAD_CELL);
        state_d   = S_LK;
      end
      S_LK: begin
        tail_d     = -rb;
        req.wbe    = 1'b1;
        req.wce    = 1'b1;
        req.waddr  = o_q;
        req.wbase  = mem_rd_i.base;
        req.wcheck = dat_pkg::cell_t'(-dat_pkg::HEAD_CELL);
        state_d    = S_LKT;
      end
      S_LKT: begin
        if (in_rng(tail_q)) begin
          req.wce    = 1'b1;
          req.waddr  = ad(tail_q);
          req.wcheck = dat_pkg::cell_t'(-dat_pkg::pos_t'(o_q));
        end
        state_d = S_LKH;
      end
      S_LKH: begin
        req.wbe   = 1'b1;
        req.waddr = ad(dat_pkg::HEAD_CELL);
        req.wbase = dat_pkg::cell_t'(-dat_pkg::pos_t'(o_q));
        i_d       = i_q + 1'b1;
        state_d   = S_MV;
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      init_q  <= '0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;     node_q <= node_d;     sym_q <= sym_d;
    nb_q <= nb_d;         mvb_q <= mvb_d;       b_q <= b_d;
    s_q <= s_d;           p_q <= p_d;           nx_q <= nx_d;
    tail_q <= tail_d;     guard_q <= guard_d;   i_q <= i_d;
    j_q <= j_d;           lo_q <= lo_d;         hi_q <= hi_d;
    kids_q <= kids_d;     newbase_q <= newbase_d;
    ulmv_q <= ulmv_d;     o_q <= o_d;           n_q <= n_d;
    g_q <= g_d;           slot_q <= slot_d;     rnode_q <= rnode_d;
    rsym_q <= rsym_d;     st_q <= st_d;
  end

  assign mem_req_o     = req;
  assign res_o.node    = rnode_q;
  assign res_o.symbol  = rsym_q;
  assign res_o.status  = st_q;

  `DAT_ASSERT_NEVER(a_no_rw_clash, clk_i, rst_ni, req.re && (req.wbe || req.wce) && (req.raddr == req.waddr), "read and write to the same cell in one cycle")
  `DAT_ASSERT_NEVER(a_wr_range, clk_i, rst_ni, (req.wbe || req.wce) && ({1'b0, req.waddr} >= (dat_pkg::ADDR_W+1)'(CELLS)), "write beyond table")
  `DAT_ASSERT_NEVER(a_rd_range, clk_i, rst_ni, req.re && ({1'b0, req.raddr} >= (dat_pkg::ADDR_W+1)'(CELLS)), "read beyond table")
  `DAT_ASSERT(a_init_once, clk_i, rst_ni, (state_q != S_INIT) |=> (state_q != S_INIT), "init sweep re-entered")
  `DAT_ASSERT(a_one_item, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o, "second transaction taken while busy")

endmodule

[rtl/double_array_trie_engine.sv]
`timescale 1ns / 1ps
// Lookup and symbol read: the node cell is read, then if needed the child slot or parent cell.
// Insert is data dependent: sibling collection reads each old slot; each free-list candidate
// takes a bitmap scan over the symbols with a read per sibling; relocation reads each
// old slot, moves each child and rescans its grandchild slots; the child is placed last.
// One transaction in flight; its steps share the single memory read port.
// Reset: an init sweep writes all CELLS cells of the initial table before the first input is taken.
// ---------------------------------------------------------------------------
// double_array_trie_engine
// Double-array trie store with free-list allocation and sibling relocation.
// ---------------------------------------------------------------------------
module double_array_trie_engine #(
  parameter int CELLS   = 4096,
  parameter int SYMBOLS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [11:0] node_i,
  input  logic [7:0]  symbol_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] result_node_o,
  output logic [7:0]  result_symbol_o,
  output logic [1:0]  status_o
);

  dat_pkg::mem_req_t mem_req;
  dat_pkg::cell_rd_t mem_rd;
  dat_pkg::res_t     res, out_q;
  logic              res_valid, res_ready;
  logic              out_valid_q;

  dat_mem #(.CELLS(CELLS)) u_mem (
    .clk_i (clk_i),
    .req_i (mem_req),
    .rd_o  (mem_rd)
  );

  dat_seq #(.CELLS(CELLS), .SYMBOLS(SYMBOLS)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .node_i      (node_i),
    .symbol_i    (symbol_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rd_i    (mem_rd)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_node_o   = out_q.node;
  assign result_symbol_o = out_q.symbol;
  assign status_o        = out_q.status;

endmodule
